### hdl/v3alu_pkg.sv
// Shared types, operation and status codes, and the saturation helper for the
// three-component vector arithmetic unit. No dependencies.
`default_nettype none

package v3alu_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS_DEF = 16;
  // Room for a sum of three full products plus sign.
  localparam int WIDE_BITS     = 2 * WORD_BITS + 2;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_SCALE = 4'd2,
    OP_DIV   = 4'd3,
    OP_DOT   = 4'd4,
    OP_CROSS = 4'd5,
    OP_SQLEN = 4'd6,
    OP_LEN   = 4'd7,
    OP_NORM  = 4'd8
  } v3alu_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_LEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_SAT      = 2'd3
  } v3alu_status_t;

  typedef logic signed [WORD_BITS-1:0] v3alu_word_t;

  typedef struct packed {
    logic [3:0]  operation;
    v3alu_word_t a_x;
    v3alu_word_t a_y;
    v3alu_word_t a_z;
    v3alu_word_t b_x;
    v3alu_word_t b_y;
    v3alu_word_t b_z;
  } v3alu_in_t;

  typedef struct packed {
    v3alu_word_t r_x;
    v3alu_word_t r_y;
    v3alu_word_t r_z;
    v3alu_word_t scalar_out;
    logic [1:0]  status;
  } v3alu_out_t;

  // Everything an item carries alongside the square root and divider pipes.
  typedef struct packed {
    logic [3:0]  op;
    v3alu_word_t a_x;
    v3alu_word_t a_y;
    v3alu_word_t a_z;
    v3alu_word_t bx;
    v3alu_word_t r_x;
    v3alu_word_t r_y;
    v3alu_word_t r_z;
    v3alu_word_t sc;
    logic [1:0]  status;
    logic        div_use;
  } v3alu_side_t;

  typedef struct packed {
    logic        ovf;
    v3alu_word_t val;
  } v3alu_sat_t;

  // Clamp a wide signed value to the word range and flag when it clamps.
  function automatic v3alu_sat_t v3alu_sat(input logic signed [WIDE_BITS-1:0] v);
    v3alu_sat_t                   res;
    logic [WIDE_BITS-WORD_BITS:0] hi_bits;
    hi_bits = v[WIDE_BITS-1:WORD_BITS-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      res.ovf = 1'b0;
      res.val = v[WORD_BITS-1:0];
    end else begin
      res.ovf = 1'b1;
      res.val = v[WIDE_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                               : {1'b0, {(WORD_BITS-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/v3alu_lane.sv
// One component lane: two products, add/sub, and the saturated per-component
// result for add, sub, scale and cross. Depends on v3alu_pkg.
`default_nettype none

module v3alu_lane
  import v3alu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [3:0]                    op_in,
  input  wire logic [3:0]                    op_s1,
  input  wire v3alu_word_t                   a_i,
  input  wire v3alu_word_t                   a_j,
  input  wire v3alu_word_t                   a_k,
  input  wire v3alu_word_t                   b_i,
  input  wire v3alu_word_t                   b_j,
  input  wire v3alu_word_t                   b_k,
  input  wire v3alu_word_t                   bx,
  output logic signed [2*WORD_BITS-1:0]      m0_r,
  output v3alu_sat_t                         res_r
);

  localparam int PW = 2 * WORD_BITS;

  v3alu_word_t                mul_a;
  v3alu_word_t                mul_b;
  logic signed [PW-1:0]       m0_nxt;
  logic signed [PW-1:0]       m1_nxt;
  logic signed [PW-1:0]       m1_r;
  logic signed [WORD_BITS:0]  as_nxt;
  logic signed [WORD_BITS:0]  as_r;
  logic signed [PW:0]         diff;
  logic signed [WIDE_BITS-1:0] wide_val;
  v3alu_sat_t                 res_nxt;

  always_comb begin
    mul_a = a_i;
    mul_b = b_i;
    case (op_in)
      OP_SCALE: mul_b = bx;
      OP_CROSS: begin
        mul_a = a_j;
        mul_b = b_k;
      end
      OP_SQLEN, OP_LEN, OP_NORM: mul_b = a_i;
      default: mul_b = b_i;
    endcase
    m0_nxt = mul_a * mul_b;
    m1_nxt = a_k * b_j;
    if (op_in == OP_SUB) begin
      as_nxt = {a_i[WORD_BITS-1], a_i} - {b_i[WORD_BITS-1], b_i};
    end else begin
      as_nxt = {a_i[WORD_BITS-1], a_i} + {b_i[WORD_BITS-1], b_i};
    end
  end

  always_comb begin
    diff = {m0_r[PW-1], m0_r} - {m1_r[PW-1], m1_r};
    case (op_s1)
      OP_ADD, OP_SUB: wide_val = WIDE_BITS'(as_r);
      OP_SCALE:       wide_val = WIDE_BITS'(m0_r >>> FRAC_BITS);
      OP_CROSS:       wide_val = WIDE_BITS'(diff >>> FRAC_BITS);
      default:        wide_val = '0;
    endcase
    res_nxt = v3alu_sat(wide_val);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r  <= m0_nxt;
      m1_r  <= m1_nxt;
      as_r  <= as_nxt;
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/v3alu_sqrt.sv
// Pipelined integer square root, one root bit per stage, carrying the item's
// sideband alongside. Depends on v3alu_pkg.
`default_nettype none

module v3alu_sqrt
  import v3alu_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_vld,
  input  wire v3alu_side_t              in_side,
  input  wire logic [2*WORD_BITS-1:0]   in_sq,
  output logic                          out_vld,
  output v3alu_side_t                   out_side,
  output logic [WORD_BITS-1:0]          out_root
);

  localparam int N  = WORD_BITS;
  localparam int RW = WORD_BITS + 1;

  logic              vld_r   [N];
  v3alu_side_t       side_r  [N];
  logic [2*N-1:0]    sq_r    [N];
  logic [RW-1:0]     rem_r   [N];
  logic [N-1:0]      root_r  [N];

  logic [2*N-1:0]    sq_in   [N];
  logic [RW-1:0]     rem_in  [N];
  logic [N-1:0]      root_in [N];
  logic [RW+1:0]     t_rem   [N];
  logic [RW+1:0]     t_sub   [N];
  logic              ge      [N];
  logic [2*N-1:0]    sq_nxt  [N];
  logic [RW-1:0]     rem_nxt [N];
  logic [N-1:0]      root_nxt[N];

  // Each stage brings down the next two radicand bits from the top of a
  // shifting copy and tries appending a one to the root.
  always_comb begin
    sq_in[0]   = in_sq;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int k = 1; k < N; k++) begin
      sq_in[k]   = sq_r[k-1];
      rem_in[k]  = rem_r[k-1];
      root_in[k] = root_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      t_rem[k]    = {rem_in[k], sq_in[k][2*N-1 -: 2]};
      t_sub[k]    = {1'b0, root_in[k], 2'b01};
      ge[k]       = t_rem[k] >= t_sub[k];
      rem_nxt[k]  = ge[k] ? RW'(t_rem[k] - t_sub[k]) : RW'(t_rem[k]);
      root_nxt[k] = {root_in[k][N-2:0], ge[k]};
      sq_nxt[k]   = {sq_in[k][2*N-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < N; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int k = 1; k < N; k++) begin
        side_r[k] <= side_r[k-1];
      end
      for (int k = 0; k < N; k++) begin
        sq_r[k]   <= sq_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_side = side_r[N-1];
  assign out_root = root_r[N-1];

endmodule

`default_nettype wire

### hdl/v3alu_div.sv
// Pipelined restoring divider for one lane, one quotient bit per stage, on
// the magnitude of a fixed-point dividend. Depends on v3alu_pkg.
`default_nettype none

module v3alu_div
  import v3alu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [WORD_BITS-1:0]           in_mag,
  input  wire logic [WORD_BITS-1:0]           in_dvs,
  input  wire logic                           in_neg,
  output logic [WORD_BITS+FRAC_BITS-1:0]      out_quo,
  output logic                                out_neg
);

  localparam int N = WORD_BITS + FRAC_BITS;
  localparam int W = WORD_BITS;

  logic [N-1:0] num_r   [N];
  logic [W-1:0] dvs_r   [N];
  logic         neg_r   [N];
  logic [W-1:0] rem_r   [N];
  logic [N-1:0] quo_r   [N];

  logic [N-1:0] num_in  [N];
  logic [W-1:0] dvs_in  [N];
  logic         neg_in  [N];
  logic [W-1:0] rem_in  [N];
  logic [N-1:0] quo_in  [N];
  logic [W:0]   trial   [N];
  logic         ge      [N];
  logic [W-1:0] rem_nxt [N];

  always_comb begin
    num_in[0] = {in_mag, {FRAC_BITS{1'b0}}};
    dvs_in[0] = in_dvs;
    neg_in[0] = in_neg;
    rem_in[0] = '0;
    quo_in[0] = '0;
    for (int k = 1; k < N; k++) begin
      num_in[k] = num_r[k-1];
      dvs_in[k] = dvs_r[k-1];
      neg_in[k] = neg_r[k-1];
      rem_in[k] = rem_r[k-1];
      quo_in[k] = quo_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      trial[k]   = {rem_in[k], num_in[k][N-1]};
      ge[k]      = trial[k] >= {1'b0, dvs_in[k]};
      rem_nxt[k] = ge[k] ? W'(trial[k] - {1'b0, dvs_in[k]}) : trial[k][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        num_r[k] <= {num_in[k][N-2:0], 1'b0};
        dvs_r[k] <= dvs_in[k];
        neg_r[k] <= neg_in[k];
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= {quo_in[k][N-2:0], ge[k]};
      end
    end
  end

  assign out_quo = quo_r[N-1];
  assign out_neg = neg_r[N-1];

endmodule

`default_nettype wire

### hdl/vector3_arithmetic_unit_core.sv
// Three-lane vector arithmetic unit on signed fixed-point words.
// Pipeline: product, dot-sum and merge stages, then the one-bit-per-stage square
// root and divider pipelines and the output register (Q16.16 by default).
// Throughput: one item per cycle; the whole pipe holds only while a result
// waits at the output and the last pipe stage is occupied.
// Reset clears the stage valid bits and the output valid; data is not reset.
`default_nettype none

module vector3_arithmetic_unit_core
  import v3alu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire v3alu_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output v3alu_out_t      out_data
);

  localparam int PW         = 2 * WORD_BITS;
  localparam int DIV_STAGES = WORD_BITS + FRAC_BITS;
  localparam int QW         = WORD_BITS + FRAC_BITS;

  logic                          en;
  logic                          vld1_r;
  logic                          vld2_r;
  logic                          vld3_r;
  v3alu_side_t                   side1_nxt;
  v3alu_side_t                   side1_r;
  v3alu_side_t                   side2_r;
  v3alu_side_t                   side3_nxt;
  v3alu_side_t                   side3_r;
  v3alu_word_t                   a_v [3];
  v3alu_word_t                   b_v [3];
  logic signed [PW-1:0]          m0 [3];
  v3alu_sat_t                    lane_res [3];
  logic signed [WIDE_BITS-1:0]   dot_nxt;
  logic signed [WIDE_BITS-1:0]   dot_r;
  v3alu_sat_t                    dot_sat;
  logic [PW-1:0]                 sq_r;

  logic                          sq_vld;
  v3alu_side_t                   sq_side;
  logic [WORD_BITS-1:0]          sq_root;

  v3alu_side_t                   ds_nxt;
  v3alu_sat_t                    len_sat;
  logic [WORD_BITS-1:0]          dvs;
  logic [WORD_BITS-1:0]          bx_mag;
  logic [WORD_BITS-1:0]          div_mag [3];
  logic                          div_neg [3];
  logic [QW-1:0]                 quo [3];
  logic                          quo_neg [3];
  logic                          dvld_r [DIV_STAGES];
  v3alu_side_t                   dside_r [DIV_STAGES];

  logic signed [WIDE_BITS-1:0]   qw [3];
  v3alu_sat_t                    q_sat [3];
  v3alu_side_t                   fs;
  v3alu_out_t                    out_nxt;
  v3alu_out_t                    out_r;
  logic                          out_valid_r;

  // The pipe keeps moving unless a result is parked and another is due.
  assign en       = !out_valid_r || out_ready || !dvld_r[DIV_STAGES-1];
  assign in_ready = en;

  assign a_v[0] = in_data.a_x;
  assign a_v[1] = in_data.a_y;
  assign a_v[2] = in_data.a_z;
  assign b_v[0] = in_data.b_x;
  assign b_v[1] = in_data.b_y;
  assign b_v[2] = in_data.b_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3alu_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .op_in (in_data.operation),
      .op_s1 (side1_r.op),
      .a_i   (a_v[i]),
      .a_j   (a_v[(i+1)%3]),
      .a_k   (a_v[(i+2)%3]),
      .b_i   (b_v[i]),
      .b_j   (b_v[(i+1)%3]),
      .b_k   (b_v[(i+2)%3]),
      .bx    (in_data.b_x),
      .m0_r  (m0[i]),
      .res_r (lane_res[i])
    );
  end

  always_comb begin
    side1_nxt     = '0;
    side1_nxt.op  = in_data.operation;
    side1_nxt.a_x = in_data.a_x;
    side1_nxt.a_y = in_data.a_y;
    side1_nxt.a_z = in_data.a_z;
    side1_nxt.bx  = in_data.b_x;
    dot_nxt = WIDE_BITS'(m0[0]) + WIDE_BITS'(m0[1]) + WIDE_BITS'(m0[2]);
  end

  // Merge stage: lane results, the dot-sum scalar (dot, sqlen only) and status.
  always_comb begin
    side3_nxt     = side2_r;
    side3_nxt.r_x = lane_res[0].val;
    side3_nxt.r_y = lane_res[1].val;
    side3_nxt.r_z = lane_res[2].val;
    dot_sat       = v3alu_sat(dot_r >>> FRAC_BITS);
    if (side2_r.op == OP_DOT || side2_r.op == OP_SQLEN) begin
      side3_nxt.sc = dot_sat.val;
    end else begin
      side3_nxt.sc = '0;
      dot_sat.ovf  = 1'b0;
    end
    if (lane_res[0].ovf || lane_res[1].ovf || lane_res[2].ovf || dot_sat.ovf) begin
      side3_nxt.status = ST_SAT;
    end else if (side2_r.op == OP_DIV && side2_r.bx == '0) begin
      side3_nxt.status = ST_DIV_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side1_nxt;
      side2_r <= side1_r;
      dot_r   <= dot_nxt;
      side3_r <= side3_nxt;
      sq_r    <= dot_r[PW-1:0];
    end
  end

  v3alu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld3_r),
    .in_side  (side3_r),
    .in_sq    (sq_r),
    .out_vld  (sq_vld),
    .out_side (sq_side),
    .out_root (sq_root)
  );

  // Length results and the divider setup, once the root is known.
  always_comb begin
    ds_nxt  = sq_side;
    len_sat = v3alu_sat(WIDE_BITS'(sq_root));
    bx_mag  = sq_side.bx[WORD_BITS-1] ? WORD_BITS'(0 - sq_side.bx) : sq_side.bx;
    case (sq_side.op)
      OP_LEN: begin
        ds_nxt.sc = len_sat.val;
        if (len_sat.ovf) begin
          ds_nxt.status = ST_SAT;
        end
      end
      OP_NORM: begin
        if (sq_root == '0) begin
          ds_nxt.r_x    = sq_side.a_x;
          ds_nxt.r_y    = sq_side.a_y;
          ds_nxt.r_z    = sq_side.a_z;
          ds_nxt.status = ST_ZERO_LEN;
        end else begin
          ds_nxt.div_use = 1'b1;
        end
      end
      OP_DIV: ds_nxt.div_use = (sq_side.bx != '0);
      default: ds_nxt.div_use = 1'b0;
    endcase
    dvs = (sq_side.op == OP_DIV) ? bx_mag : sq_root;
    div_mag[0] = sq_side.a_x[WORD_BITS-1] ? WORD_BITS'(0 - sq_side.a_x) : sq_side.a_x;
    div_mag[1] = sq_side.a_y[WORD_BITS-1] ? WORD_BITS'(0 - sq_side.a_y) : sq_side.a_y;
    div_mag[2] = sq_side.a_z[WORD_BITS-1] ? WORD_BITS'(0 - sq_side.a_z) : sq_side.a_z;
    div_neg[0] = sq_side.a_x[WORD_BITS-1] ^ (sq_side.op == OP_DIV && sq_side.bx[WORD_BITS-1]);
    div_neg[1] = sq_side.a_y[WORD_BITS-1] ^ (sq_side.op == OP_DIV && sq_side.bx[WORD_BITS-1]);
    div_neg[2] = sq_side.a_z[WORD_BITS-1] ^ (sq_side.op == OP_DIV && sq_side.bx[WORD_BITS-1]);
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3alu_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk     (clk),
      .en      (en),
      .in_mag  (div_mag[i]),
      .in_dvs  (dvs),
      .in_neg  (div_neg[i]),
      .out_quo (quo[i]),
      .out_neg (quo_neg[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        dvld_r[k] <= 1'b0;
      end
    end else if (en) begin
      dvld_r[0] <= sq_vld;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dvld_r[k] <= dvld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dside_r[0] <= ds_nxt;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dside_r[k] <= dside_r[k-1];
      end
    end
  end

  // Apply the quotient sign and clamp; quotients replace the vector only
  // for a real divide or a normalize of a nonzero vector.
  always_comb begin
    fs = dside_r[DIV_STAGES-1];
    for (int i = 0; i < 3; i++) begin
      qw[i]    = quo_neg[i] ? -WIDE_BITS'(quo[i]) : WIDE_BITS'(quo[i]);
      q_sat[i] = v3alu_sat(qw[i]);
    end
    out_nxt.scalar_out = fs.sc;
    if (fs.div_use) begin
      out_nxt.r_x    = q_sat[0].val;
      out_nxt.r_y    = q_sat[1].val;
      out_nxt.r_z    = q_sat[2].val;
      out_nxt.status = (q_sat[0].ovf || q_sat[1].ovf || q_sat[2].ovf) ? ST_SAT : fs.status;
    end else begin
      out_nxt.r_x    = fs.r_x;
      out_nxt.r_y    = fs.r_y;
      out_nxt.r_z    = fs.r_z;
      out_nxt.status = fs.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && dvld_r[DIV_STAGES-1]) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && dvld_r[DIV_STAGES-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && dvld_r[DIV_STAGES-1]))
    else $error("input stalled without a parked result");

  a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (en && dvld_r[DIV_STAGES-1]) |=> out_valid_r)
    else $error("finished item did not reach the output");

  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_DIV_ZERO) |->
      (out_r.r_x == '0 && out_r.r_y == '0 && out_r.r_z == '0 && out_r.scalar_out == '0))
    else $error("divide by zero result not cleared");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_ZERO_LEN) |-> out_r.scalar_out == '0)
    else $error("zero-length normalize carries a scalar");

endmodule

`default_nettype wire
